### rtl/sckx_pkg.sv
// ----------------------------------------------------------------------------
// sckx_pkg
// Shared types, constants and SHA-256 helper functions for the keystream unit.
// ----------------------------------------------------------------------------
package sckx_pkg;

    localparam int KEY_WORDS    = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int KS_WORDS     = 8;
    localparam int KS_ADDR_W    = 3;
    localparam int POS_W        = 5;
    localparam int ROUNDS_W     = 6;
    localparam logic [31:0] MSG_BITS = 32'd288;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic                 start;
        logic [KS_ADDR_W-1:0] word_sel;
    } cmp_ctl_t;

    // Status from the compression unit.
    typedef struct packed {
        logic busy;
        logic done;
    } cmp_stat_t;

    function automatic logic [31:0] init_h(input logic [KS_ADDR_W-1:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0:    h = 32'h6a09e667;
            3'd1:    h = 32'hbb67ae85;
            3'd2:    h = 32'h3c6ef372;
            3'd3:    h = 32'ha54ff53a;
            3'd4:    h = 32'h510e527f;
            3'd5:    h = 32'h9b05688c;
            3'd6:    h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(input logic [ROUNDS_W-1:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/sckx_ks_mem.sv
// ----------------------------------------------------------------------------
// sckx_ks_mem
// Keystream block store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sckx_ks_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [sckx_pkg::KS_ADDR_W-1:0] waddr,
    input  logic [31:0]                   wdata,
    input  logic [sckx_pkg::KS_ADDR_W-1:0] raddr,
    output logic [31:0]                   rdata
);
    import sckx_pkg::*;

    logic [31:0] mem [KS_WORDS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/sckx_compress.sv
// ----------------------------------------------------------------------------
// sckx_compress
// One SHA-256 compression of key and counter, one round per cycle.
// ----------------------------------------------------------------------------
module sckx_compress (
    input  logic                clk,
    input  logic                rst_n,
    input  sckx_pkg::cmp_ctl_t  ctl,
    input  logic [255:0]        key,
    input  logic [31:0]         counter,
    output sckx_pkg::cmp_stat_t stat,
    output logic [31:0]         digest_word
);
    import sckx_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROUNDS_W-1:0] round_reg, round_next;
    logic [31:0]         v_reg [8];
    logic [31:0]         v_next [8];
    logic [31:0]         w_reg [16];
    logic [31:0]         w_next [16];
    logic [31:0]         t1, t2, w_new, s0, s1;

    // Round logic and message schedule window.
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(round_reg) + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

        busy_next  = busy_reg;
        done_next  = 1'b0;
        round_next = round_reg;
        v_next     = v_reg;
        w_next     = w_reg;

        if (ctl.start)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = init_h(KS_ADDR_W'(i));
                w_next[i] = key[255 - 32*i -: 32];
            end
            w_next[8]  = {counter[7:0], counter[15:8], counter[23:16], counter[31:24]};
            w_next[9]  = PAD_WORD;
            for (int i = 10; i < 15; i++)
            begin
                w_next[i] = '0;
            end
            w_next[15] = MSG_BITS;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            round_next = round_reg + 1'b1;
            if (round_reg == ROUNDS_W'(63))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    // Working words and schedule window.
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    // Final digest word for the selected position.
    assign digest_word = init_h(ctl.word_sel) + v_reg[ctl.word_sel];
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;

endmodule

### rtl/sha256_counter_keystream_xor_unit.sv
// Each accepted byte passes through ST_READ and ST_DATA, where the result is registered
// once the output register is free. At the first byte of each 32-byte block the sequencer
// first waits in ST_HASH for the 64 compression rounds and the done flag, then makes
// 8 store writes in ST_FILL. No new byte is taken until the current one leaves ST_DATA;
// the single round unit sets the block cost.
// Reset clears position, counter, key registers and handshake state.
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor_unit
// XORs a byte stream with a SHA-256 counter-mode keystream.
// ----------------------------------------------------------------------------
module sha256_counter_keystream_xor_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sckx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sckx_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sckx_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sckx_pkg::out_word_t                 out_word
);
    import sckx_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HASH = 5'b00010,
        ST_FILL = 5'b00100,
        ST_READ = 5'b01000,
        ST_DATA = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_DATA_W-1:0] key_reg [KEY_WORDS];
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [31:0]          ctr_reg, ctr_next;
    logic [KS_ADDR_W-1:0] fill_reg, fill_next;
    in_word_t             hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg, out_word_next;
    cmp_ctl_t             cmp_ctl;
    cmp_stat_t            cmp_stat;
    logic [31:0]          digest_word;
    logic [31:0]          rd_data;
    logic [7:0]           ks_byte;
    logic                 in_take, out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_0: key_reg[0] <= cfg_data;
                REG_KEY_1: key_reg[1] <= cfg_data;
                REG_KEY_2: key_reg[2] <= cfg_data;
                REG_KEY_3: key_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    sckx_compress u_compress (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (cmp_ctl),
        .key         ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .counter     (ctr_reg),
        .stat        (cmp_stat),
        .digest_word (digest_word)
    );

    sckx_ks_mem u_ks_mem (
        .clk   (clk),
        .we    (state_reg == ST_FILL),
        .waddr (fill_reg),
        .wdata (digest_word),
        .raddr (pos_reg[POS_W-1:2]),
        .rdata (rd_data)
    );

    // Byte select, first byte in the most significant lane.
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    ks_byte = rd_data[31:24];
            2'd1:    ks_byte = rd_data[23:16];
            2'd2:    ks_byte = rd_data[15:8];
            default: ks_byte = rd_data[7:0];
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        fill_next      = fill_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        cmp_ctl.start    = 1'b0;
        cmp_ctl.word_sel = fill_reg;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    hold_next = in_word;
                    if (pos_reg == '0)
                    begin
                        cmp_ctl.start = 1'b1;
                        state_next    = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_HASH:
            begin
                fill_next = '0;
                if (cmp_stat.done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                fill_next = fill_reg + 1'b1;
                if (fill_reg == KS_ADDR_W'(KS_WORDS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.out_byte = hold_reg.data_byte ^ ks_byte;
                    out_word_next.out_last = hold_reg.is_last;
                    if (hold_reg.is_last)
                    begin
                        pos_next = '0;
                        ctr_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        if (pos_reg == '1)
                        begin
                            ctr_next = ctr_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ctr_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A compression ends only while the sequencer waits for it.
    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_stat.done |-> state_reg == ST_HASH)
        else $error("compression finished outside of hash wait");

    // A word in the middle of a block skips the compression.
    a_mid_block_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && pos_reg != '0 |=> state_reg == ST_READ)
        else $error("mid-block word did not go to the store read");

    // A new result is produced only from the data state.
    a_result_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DATA)
        else $error("result raised outside the data state");

    // The round unit is idle whenever new words are taken.
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> !cmp_stat.busy)
        else $error("word accepted while compression busy");

endmodule

### tb/sha256_counter_keystream_xor_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor_unit_checker
// Watches the input and output channels and the key writes, computes each
// expected output word from its own keystream model and compares in order.
// ----------------------------------------------------------------------------
module sha256_counter_keystream_xor_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sckx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sckx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  sckx_pkg::in_word_t              in_word,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  sckx_pkg::out_word_t             out_word,
    output int                              fail_count,
    output int                              pending_count
);
    import sckx_pkg::*;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [63:0] key_regs [KEY_WORDS];
    logic [7:0]  ks_bytes [32];
    logic [31:0] blk_ctr;
    logic [4:0]  byte_pos;
    out_word_t   expected_words [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Hash key || little-endian counter into the keystream byte store.
    task automatic refresh_keystream();
        logic [31:0] sched [16];
        logic [31:0] st [8];
        logic [31:0] wi, t1, t2, a, b, h;
        for (int i = 0; i < 4; i++)
        begin
            sched[2*i]   = key_regs[i][63:32];
            sched[2*i+1] = key_regs[i][31:0];
        end
        sched[8] = {blk_ctr[7:0], blk_ctr[15:8], blk_ctr[23:16], blk_ctr[31:24]};
        sched[9] = 32'h8000_0000;
        for (int i = 10; i < 15; i++)
            sched[i] = '0;
        sched[15] = 32'd288;
        st = SHA_H0;
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
                wi = sched[i];
            else
            begin
                a = sched[(i-15) & 15];
                b = sched[(i-2) & 15];
                wi = sched[i & 15] + (ror32(a, 7) ^ ror32(a, 18) ^ (a >> 3))
                   + sched[(i-7) & 15] + (ror32(b, 17) ^ ror32(b, 19) ^ (b >> 10));
                sched[i & 15] = wi;
            end
            t1 = st[7] + (ror32(st[4], 6) ^ ror32(st[4], 11) ^ ror32(st[4], 25))
               + ((st[4] & st[5]) ^ (~st[4] & st[6])) + SHA_K[i] + wi;
            t2 = (ror32(st[0], 2) ^ ror32(st[0], 13) ^ ror32(st[0], 22))
               + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
            st[7] = st[6]; st[6] = st[5]; st[5] = st[4]; st[4] = st[3] + t1;
            st[3] = st[2]; st[2] = st[1]; st[1] = st[0]; st[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            h = SHA_H0[i] + st[i];
            {ks_bytes[4*i], ks_bytes[4*i+1], ks_bytes[4*i+2], ks_bytes[4*i+3]} = h;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        fail_count++;
    endtask

    assign pending_count = expected_words.size();

    // Track key writes, predict each accepted word and check each result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
                key_regs[i] = '0;
            blk_ctr = '0;
            byte_pos = '0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", out_word));
                else
                begin
                    out_word_t exp_w;
                    exp_w = expected_words.pop_front();
                    if (out_word.out_byte !== exp_w.out_byte)
                        report_mismatch($sformatf("out_byte %h expected %h",
                                        out_word.out_byte, exp_w.out_byte));
                    if (out_word.out_last !== exp_w.out_last)
                        report_mismatch($sformatf("out_last %b expected %b",
                                        out_word.out_last, exp_w.out_last));
                end
            end
            if (in_valid && !in_stall)
            begin
                out_word_t nw;
                if (byte_pos == 0)
                    refresh_keystream();
                nw.out_byte = in_word.data_byte ^ ks_bytes[byte_pos];
                nw.out_last = in_word.is_last;
                expected_words.push_back(nw);
                if (in_word.is_last)
                begin
                    byte_pos = '0;
                    blk_ctr = '0;
                end
                else
                begin
                    byte_pos = byte_pos + 5'd1;
                    if (byte_pos == 0)
                        blk_ctr = blk_ctr + 32'd1;
                end
            end
            if (cfg_we && cfg_index < KEY_WORDS)
                key_regs[cfg_index[1:0]] = cfg_data;
        end
    end

endmodule

### tb/sha256_counter_keystream_xor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor_unit_test
// Drives directed and random byte messages with random gaps and stalls
// through the keystream unit, changes keys between phases, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module sha256_counter_keystream_xor_unit_test;
    import sckx_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    int                    fail_count;
    int                    pending_count;
    bit                    hold_off_req;
    bit                    stim_done;

    sha256_counter_keystream_xor_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    sha256_counter_keystream_xor_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 120);
    endfunction

    // Receiver stall, with one long forced hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
            end
            n = gap_length();
            if (n > 0 && !stim_done)
            begin
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_key(REG_KEY_0, k0);
        write_key(REG_KEY_1, k1);
        write_key(REG_KEY_2, k2);
        write_key(REG_KEY_3, k3);
    endtask

    // Offer one word and hold it until accepted; inputs change on falling edges.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
        int n;
        n = gaps ? gap_length() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{data_byte: b, is_last: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(0, 255), i == len - 1, 1'b1);
    endtask

    initial
    begin
        int count;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all-zero key from reset, extremes of data, last in mid-block.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'ha5, 1'b1, 1'b0);
        send_byte(8'h5a, 1'b1, 1'b0);
        drain();
        load_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        // A write to an unused index must be ignored.
        write_key(3'd5, 64'h0123_4567_89ab_cdef);
        write_key(3'd7, 64'hdead_beef_dead_beef);
        // Crossing a block boundary: 34 bytes, last at the end.
        for (int i = 0; i < 34; i++)
            send_byte(i[0] ? 8'hff : 8'h00, i == 33, 1'b0);
        drain();

        // Key written mid-block: held block keeps the old key.
        send_byte(8'h11, 1'b0, 1'b0);
        drain();
        write_key(REG_KEY_2, 64'h8000_0000_0000_0001);
        for (int i = 0; i < 40; i++)
            send_byte($urandom_range(0, 255), i == 39, 1'b0);
        drain();

        // Random key, long receiver hold-off while the sender keeps offering.
        load_key({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        hold_off_req = 1'b1;
        random_message(100);
        drain();

        // Random phases with new keys between them.
        count = 0;
        while (count < 950)
        begin
            int len;
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 3);
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(60, 130);
            else
                len = $urandom_range(4, 40);
            random_message(len);
            count += len;
            if ($urandom_range(0, 4) == 0)
            begin
                drain();
                load_key({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            end
        end
        // Finish with a message left open at a non-zero position and counter.
        for (int i = 0; i < 70; i++)
            send_byte($urandom_range(0, 255), 1'b0, 1'b1);
        stim_done = 1'b1;
        drain();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/sckx_pkg.sv
rtl/sckx_ks_mem.sv
rtl/sckx_compress.sv
rtl/sha256_counter_keystream_xor_unit.sv
tb/sha256_counter_keystream_xor_unit_checker.sv
tb/sha256_counter_keystream_xor_unit_test.sv
